FILE: rtl/event_log_intensity_integrator_macros.svh
// ----------------------------------------------------------------------------
// Event log intensity integrator: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EVENT_LOG_INTENSITY_INTEGRATOR_MACROS_SVH
`define EVENT_LOG_INTENSITY_INTEGRATOR_MACROS_SVH

// Same-cycle implication.
`define ELI_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ELI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/eli_pkg.sv
// ----------------------------------------------------------------------------
// Event log intensity integrator: package
// Frame geometry, payload types, decay table and shared control types.
// ----------------------------------------------------------------------------
package eli_pkg;

	localparam int FRAME_WIDTH         = 640;
	localparam int FRAME_HEIGHT        = 480;
	localparam int DECAY_TABLE_ENTRIES = 128;

	localparam int NPIX   = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W = $clog2(NPIX);
	localparam int TAB_W  = $clog2(DECAY_TABLE_ENTRIES);
	localparam int LOGI_W = 24;
	localparam int FAC_W  = 17;

	typedef enum logic {
		FUNC_EVENT,
		FUNC_READ
	} func_t;

	typedef enum logic [1:0] {
		CFG_DECAY_TIME,
		CFG_CONTRAST_ON,
		CFG_CONTRAST_OFF,
		CFG_TONEMAP
	} cfg_idx_t;

	typedef struct packed {
		func_t       func;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic        polarity;
		logic [31:0] time_us;
	} req_t;

	typedef struct packed {
		logic [7:0] gray;
		logic       in_frame;
	} rsp_t;

	// Classified item as it sits in the queue between front and back.
	typedef struct packed {
		func_t             func;
		logic              polarity;
		logic              in_fov;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       time_us;
	} qent_t;

	typedef struct packed {
		logic [34:0]        decay_div;
		logic signed [15:0] on_step;
		logic signed [15:0] off_step;
		logic [19:0]        tonemap;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_RD,
		ST_DATA,
		ST_DIV,
		ST_LOOK,
		ST_MUL,
		ST_WB,
		ST_RES
	} back_state_t;

	typedef logic [FAC_W-1:0] dtab_t [DECAY_TABLE_ENTRIES];

	// Unsigned long division by shift and subtract; only used to build the table.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-x), x in Q16 below 8.0, Q16 result; Taylor series on the fraction.
	function automatic logic [FAC_W-1:0] exp_neg_q16(input logic [31:0] x);
		logic [63:0] ei [8];
		logic [63:0] f;
		logic [63:0] term;
		logic [63:0] sum;
		logic [2:0]  n;
		ei = '{64'd1073741824, 64'd395007543, 64'd145315154, 64'd53458458,
		       64'd19666267, 64'd7234816, 64'd2661540, 64'd979126};
		n = x[18:16];
		f = {48'd0, x[15:0]};
		term = 64'd1 << 30;
		sum = term;
		for (int k = 1; k <= 12; k++) begin
			// floor(term*f / (65536*k)) taken in two exact steps
			term = udiv64((term * f) >> 16, 64'(k));
			if ((k & 1) == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		return FAC_W'((sum * ei[n] + (64'd1 << 43)) >> 44);
	endfunction

	function automatic dtab_t build_decay_table();
		dtab_t t;
		for (int k = 0; k < DECAY_TABLE_ENTRIES; k++)
			t[k] = exp_neg_q16(32'((64'(k) * 64'd524288) >> TAB_W));
		return t;
	endfunction

	localparam dtab_t DECAY_TABLE = build_decay_table();

endpackage

FILE: rtl/event_log_intensity_integrator.sv
// ----------------------------------------------------------------------------
// Event log intensity integrator
// Per-pixel leaky log-intensity map fed by sensor events, with gray readout.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 307200-entry pixel store to zero, one entry
// per cycle, and holds req_stall high until the sweep ends; configuration
// writes are taken throughout. Each transaction then runs alone through the
// back end: read the store, divide the elapsed time in the decay-index divider
// (one quotient bit per cycle), look up the decay factor, multiply, write back,
// and for a read deliver the result. An elapsed time of eight decay constants
// or more skips divider and lookup and uses a zero factor. A coordinate outside
// the frame skips the store: an event is dropped, a read goes to its result.
// The front end holds two classified transactions. A finished result waits in
// the output register while rsp_stall is high; a later read then waits for it.
// ----------------------------------------------------------------------------
module event_log_intensity_integrator import eli_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	logic [31:0]        decay_q;
	logic signed [15:0] con_on_q;
	logic signed [15:0] con_off_q;
	logic [19:0]        tone_q;
	cfg_t               cfg;
	logic               clear_busy;
	logic               q_valid;
	logic               q_pop;
	qent_t              q_head;

	// Configuration registers; a write takes effect at once, so issue it only
	// while no transaction is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q   <= 32'd100000;
			con_on_q  <= 16'sd747;
			con_off_q <= -16'sd747;
			tone_q    <= 20'd3734;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DECAY_TIME:   decay_q   <= cfg_wdata;
				CFG_CONTRAST_ON:  con_on_q  <= cfg_wdata[15:0];
				CFG_CONTRAST_OFF: con_off_q <= cfg_wdata[15:0];
				CFG_TONEMAP:      tone_q    <= cfg_wdata[19:0];
				default: ;
			endcase
		end
	end

	// A zero decay constant acts as one microsecond; the divider wants 8*tau.
	always_comb begin
		cfg.decay_div = {((decay_q == '0) ? 32'd1 : decay_q), 3'b000};
		cfg.on_step   = con_on_q;
		cfg.off_step  = con_off_q;
		cfg.tonemap   = tone_q;
	end

	eli_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.clear_busy (clear_busy),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop)
	);

	eli_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.clear_busy (clear_busy),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

FILE: rtl/eli_front.sv
// ----------------------------------------------------------------------------
// Event log intensity integrator: front end
// Accept transactions, classify against the frame, queue for the back end.
// ----------------------------------------------------------------------------
module eli_front import eli_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	input  req_t  req,
	input  logic  clear_busy,
	output logic  q_valid,
	output qent_t q_head,
	input  logic  q_pop
);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	qent_t               fifo_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                push;
	logic                in_fov;
	logic [19:0]         addr_full;
	qent_t               ent;

	assign req_stall = (cnt_q == QCNT_W'(QDEPTH)) || clear_busy;
	assign push      = req_valid && !req_stall;
	assign q_valid   = (cnt_q != '0);
	assign q_head    = fifo_q[rd_ptr_q];

	always_comb begin
		in_fov    = ({1'b0, req.pixel_x} < 11'(FRAME_WIDTH)) &&
		            ({1'b0, req.pixel_y} < 11'(FRAME_HEIGHT));
		addr_full = 20'(req.pixel_y) * 20'(FRAME_WIDTH) + 20'(req.pixel_x);
		ent.func     = req.func;
		ent.polarity = req.polarity;
		ent.in_fov   = in_fov;
		ent.addr     = in_fov ? addr_full[ADDR_W-1:0] : '0;
		ent.time_us  = req.time_us;
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (q_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !q_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && q_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: rtl/eli_back.sv
// ----------------------------------------------------------------------------
// Event log intensity integrator: back end
// Pixel store, decay divider, scaling, write-back and tone-mapped readout.
// ----------------------------------------------------------------------------
`include "event_log_intensity_integrator_macros.svh"

module eli_back import eli_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	input  qent_t q_head,
	output logic  q_pop,
	output logic  clear_busy,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	output rsp_t  rsp
);

	localparam int MEM_W  = 32 + LOGI_W;
	localparam int DSH_W  = 34 + TAB_W;
	localparam int CNT_W  = (TAB_W > 1) ? $clog2(TAB_W) : 1;
	localparam int PROD_W = LOGI_W + FAC_W + 1;

	back_state_t              st_q, st_d;
	qent_t                    cur_q;
	logic [ADDR_W-1:0]        clr_q;
	logic [MEM_W-1:0]         mem [NPIX];
	logic [MEM_W-1:0]         rd_q;
	logic [DSH_W-1:0]         rem_q;
	logic [DSH_W-1:0]         dsh_q;
	logic [TAB_W-1:0]         quot_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [FAC_W-1:0]         fac_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [LOGI_W-1:0] logi_q;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;

	logic                     mem_we;
	logic                     rsp_push;
	logic [31:0]              dt;
	logic                     dt_big;
	logic                     ge;
	logic signed [PROD_W-1:0] rnd;
	logic signed [26:0]       acc;
	logic signed [15:0]       contrast;
	logic signed [LOGI_W-1:0] new_logi;
	logic signed [26:0]       d;
	logic [36:0]              ridx_prod;
	logic [21:0]              ridx;
	logic [24:0]              gmul;
	logic [8:0]               graw;
	logic [7:0]               gray;

	assign clear_busy = (st_q == ST_CLR);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// Datapath terms
	always_comb begin
		dt     = cur_q.time_us - rd_q[MEM_W-1:LOGI_W];
		dt_big = {3'b000, dt} >= cfg.decay_div;
		ge     = rem_q >= dsh_q;

		// round half away from zero to Q12
		rnd = prod_q + (prod_q[PROD_W-1] ? PROD_W'(32767) : PROD_W'(32768));
		if (cur_q.func == FUNC_EVENT)
			contrast = cur_q.polarity ? cfg.on_step : cfg.off_step;
		else
			contrast = '0;
		acc = 27'(rnd >>> 16) + 27'(contrast);
		if (acc > 27'sd8388607)
			new_logi = 24'sh7FFFFF;
		else if (acc < -27'sd8388608)
			new_logi = 24'sh800000;
		else
			new_logi = acc[LOGI_W-1:0];

		d         = $signed({7'd0, cfg.tonemap}) - 27'(logi_q);
		ridx_prod = 37'(d[25:0]) * 37'(DECAY_TABLE_ENTRIES);
		ridx      = ridx_prod[36:15];
		gmul      = 25'(DECAY_TABLE[ridx[TAB_W-1:0]]) * 25'd255 + 25'd32768;
		graw      = gmul[24:16];
		if (!cur_q.in_fov)
			gray = '0;
		else if (d[26] || d == '0)
			gray = 8'd255;
		else if (ridx >= 22'(DECAY_TABLE_ENTRIES))
			gray = '0;
		else if (graw > 9'd255)
			gray = 8'd255;
		else
			gray = graw[7:0];
	end

	// Sequencer
	always_comb begin
		st_d     = st_q;
		q_pop    = 1'b0;
		rsp_push = 1'b0;
		mem_we   = 1'b0;
		case (st_q)
			ST_CLR: begin
				mem_we = 1'b1;
				if (clr_q == ADDR_W'(NPIX - 1))
					st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_head.in_fov)
						st_d = ST_RD;
					else if (q_head.func == FUNC_READ)
						st_d = ST_RES;
				end
			end
			ST_RD:   st_d = ST_DATA;
			ST_DATA: st_d = dt_big ? ST_MUL : ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0)
					st_d = ST_LOOK;
			end
			ST_LOOK: st_d = ST_MUL;
			ST_MUL:  st_d = ST_WB;
			ST_WB: begin
				mem_we = 1'b1;
				st_d   = (cur_q.func == FUNC_READ) ? ST_RES : ST_IDLE;
			end
			ST_RES: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_push = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLR)
				clr_q <= clr_q + 1'b1;
			if (rsp_push)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// Pixel store: one write port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			if (st_q == ST_CLR)
				mem[clr_q] <= '0;
			else
				mem[cur_q.addr] <= {cur_q.time_us, new_logi};
		end
		rd_q <= mem[cur_q.addr];
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_head;
		case (st_q)
			ST_DATA: begin
				rem_q  <= DSH_W'(DSH_W'(dt) * DSH_W'(DECAY_TABLE_ENTRIES));
				dsh_q  <= DSH_W'(cfg.decay_div) << (TAB_W - 1);
				cnt_q  <= CNT_W'(TAB_W - 1);
				quot_q <= '0;
				fac_q  <= '0;
			end
			ST_DIV: begin
				if (ge)
					rem_q <= rem_q - dsh_q;
				quot_q <= {quot_q[TAB_W-2:0], ge};
				dsh_q  <= dsh_q >> 1;
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_LOOK: fac_q <= DECAY_TABLE[quot_q];
			ST_MUL:  prod_q <= PROD_W'($signed(rd_q[LOGI_W-1:0]) * $signed({1'b0, fac_q}));
			ST_WB:   logi_q <= new_logi;
			default: ;
		endcase
		if (rsp_push) begin
			rsp_q.gray     <= gray;
			rsp_q.in_frame <= cur_q.in_fov;
		end
	end

	`ELI_ASSERT_IMPLIES(a_pop_idle, q_pop, st_q == ST_IDLE && !clear_busy, "pop outside idle")
	`ELI_ASSERT_IMPLIES(a_we_state, mem_we, st_q == ST_WB || st_q == ST_CLR, "stray store write")
	`ELI_ASSERT_NEXT(a_div_end, st_q == ST_DIV && cnt_q == '0, st_q == ST_LOOK, "divider overrun")
	`ELI_ASSERT_IMPLIES(a_push_room, rsp_push, !rsp_valid_q || !rsp_stall, "result overwritten")

endmodule
